// ===== src/uerc_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranging controller.
// Holds the request/response beat structs, event codes and conversion constants.
// No dependencies.
package uerc_pkg;

   // Event codes carried in the request beat
   localparam logic [1:0] ACT_START   = 2'd0;
   localparam logic [1:0] ACT_TRIG    = 2'd1;
   localparam logic [1:0] ACT_ECHO    = 2'd2;
   localparam logic [1:0] ACT_TIMEOUT = 2'd3;

   // Phase codes as reported in the response beat
   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_TRIG = 2'd1;
   localparam logic [1:0] PHASE_RISE = 2'd2;
   localparam logic [1:0] PHASE_FALL = 2'd3;

   // Register selects, as values of the word-select bit (byte addresses 0x0 and 0x4)
   localparam logic REG_ECHO_OFFSET  = 1'b0;
   localparam logic REG_MAX_DISTANCE = 1'b1;

   localparam logic [7:0]  ECHO_OFFSET_RESET  = 8'd5;
   localparam logic [12:0] MAX_DISTANCE_RESET = 13'd2200;

   // distance = (ticks * 343) / 2000, done as ticks * ceil(343 * 2^27 / 2000) >> 27.
   // Exact for every sum up to 33022.
   localparam int unsigned CONV_SHIFT = 27;
   localparam logic [24:0] CONV_MULT  = 25'd23018341;

   typedef struct packed {
      logic [1:0]  action;
      logic [14:0] capture_count;
   } req_type;

   typedef struct packed {
      logic        trigger_level;
      logic [1:0]  phase;
      logic [12:0] distance_mm;
      logic        measure_done;
   } rsp_type;

endpackage

// ===== src/ultrasonic_echo_ranging_control.sv =====
// Top level of the ultrasonic echo ranging controller: event sequencer,
// distance conversion and APB-style register port. Depends on uerc_pkg.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  uerc_pkg::req_type (action, capture_count)
//   rsp       out         rsp_valid/rsp_stall  uerc_pkg::rsp_type (one beat per req beat)
//   csr       in/out      psel/penable/pready  echo_offset @0x0, max_distance_mm @0x4
//
// Each req beat is held in the input register, then updates the phase, done
// mark and echo count and loads the response register: one beat per cycle
// sustained while rsp is not stalled. The path from input register to
// response register is the state update, one 16x25 multiply and a compare.
// Reset (synchronous) empties both registers and restores idle and the
// register defaults. A stalled rsp beat holds; req stalls only once the
// input register is also full.
module ultrasonic_echo_ranging_control #(
   parameter int unsigned TIMEOUT_TICKS = 30000
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  uerc_pkg::req_type   req_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uerc_pkg::rsp_type   rsp_data,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   typedef enum logic [1:0] {
      ST_IDLE = uerc_pkg::PHASE_IDLE,
      ST_TRIG = uerc_pkg::PHASE_TRIG,
      ST_RISE = uerc_pkg::PHASE_RISE,
      ST_FALL = uerc_pkg::PHASE_FALL
   } phase_type;

   // ---------------- register port ----------------
   logic [7:0]  offset_ff;
   logic [12:0] max_dist_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= uerc_pkg::ECHO_OFFSET_RESET;
         max_dist_ff <= uerc_pkg::MAX_DISTANCE_RESET;
      end else if (csr_write) begin
         if (paddr[2] == uerc_pkg::REG_ECHO_OFFSET) begin
            offset_ff <= pwdata[7:0];
         end else begin
            max_dist_ff <= pwdata[12:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == uerc_pkg::REG_ECHO_OFFSET) begin
         prdata = {24'd0, offset_ff};
      end else begin
         prdata = {19'd0, max_dist_ff};
      end
   end

   // ---------------- beat flow ----------------
   logic                in_valid_ff, in_valid_in;
   uerc_pkg::req_type   in_data_ff;
   logic                out_valid_ff, out_valid_in;
   uerc_pkg::rsp_type   out_data_ff, out_data_in;
   logic                out_free;
   logic                advance;
   logic                req_take;

   // The response register frees when empty or drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // ---------------- sequencer state ----------------
   phase_type   phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [14:0] ticks_ff, ticks_in;
   logic [14:0] cap_clamped;

   // The timer cannot count past its period: clamp the capture to it
   always_comb begin
      if (17'(in_data_ff.capture_count) > 17'(TIMEOUT_TICKS)) begin
         cap_clamped = 15'(TIMEOUT_TICKS);
      end else begin
         cap_clamped = in_data_ff.capture_count;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      done_in  = done_ff;
      ticks_in = ticks_ff;
      case (in_data_ff.action)
         uerc_pkg::ACT_START: begin
            // honor a start only when idle; drop it otherwise
            if (phase_ff == ST_IDLE) begin
               phase_in = ST_TRIG;
               done_in  = 1'b0;
            end
         end
         uerc_pkg::ACT_TRIG: begin
            if (phase_ff == ST_TRIG) begin
               phase_in = ST_RISE;
            end
         end
         uerc_pkg::ACT_ECHO: begin
            // rising edge arms the fall wait; falling edge latches the count
            if (phase_ff == ST_RISE) begin
               phase_in = ST_FALL;
            end else if (phase_ff == ST_FALL) begin
               phase_in = ST_IDLE;
               done_in  = 1'b1;
               ticks_in = cap_clamped;
            end
         end
         uerc_pkg::ACT_TIMEOUT: begin
            // abort from any phase, keep the last echo count
            phase_in = ST_IDLE;
            done_in  = 1'b0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // ---------------- distance conversion ----------------
   logic [15:0] span;
   logic [40:0] product;
   logic [12:0] dist_raw;
   logic [12:0] dist_final;

   assign span     = 16'(ticks_in) + 16'(offset_ff);
   assign product  = 41'(span) * 41'(uerc_pkg::CONV_MULT);
   assign dist_raw = product[uerc_pkg::CONV_SHIFT +: 13];

   // Report zero unless the done mark is set, and also when beyond range
   always_comb begin
      if (done_in && (dist_raw <= max_dist_ff)) begin
         dist_final = dist_raw;
      end else begin
         dist_final = 13'd0;
      end
   end

   always_comb begin
      out_data_in.trigger_level = (phase_in == ST_TRIG);
      out_data_in.phase         = phase_in;
      out_data_in.distance_mm   = dist_final;
      out_data_in.measure_done  = done_in;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         ticks_ff     <= 15'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            done_ff  <= done_in;
            ticks_ff <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== src/uerc_checker.sv =====
// Port-level checks for the ultrasonic echo ranging controller, bound to the top.
// Depends on uerc_pkg and ultrasonic_echo_ranging_control.
module uerc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input uerc_pkg::rsp_type rsp_data
);

   // A held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // Pipeline comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_trig_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.trigger_level == (rsp_data.phase == uerc_pkg::PHASE_TRIG))
      else $error("trigger level disagrees with phase");

   // A finished measurement is only ever reported from idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.measure_done |-> rsp_data.phase == uerc_pkg::PHASE_IDLE)
      else $error("done mark outside idle");

   a_dist_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.measure_done |-> rsp_data.distance_mm == 13'd0)
      else $error("distance reported without a measurement");

endmodule

bind ultrasonic_echo_ranging_control uerc_checker u_uerc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
